>>> rtl/clnw_pkg.sv
// ---------------------------------------------------------------------------
// Character LCD nibble writer package
// Shared types, codes and constants for the 4-bit display bus writer.
// ---------------------------------------------------------------------------
package clnw_pkg;

   // Display lines that the wrap logic can step through.
   localparam int MAX_LINES = 4;

   // Transfers that one input item can cause at most.
   localparam int MAX_RESULTS = 4;

   // Field widths.
   localparam int MODE_W    = 2;
   localparam int VALUE_W   = 8;
   localparam int NIBBLE_W  = 4;
   localparam int SETTLE_W  = 2;
   localparam int CURSOR_W  = 8;
   localparam int COLUMNS_W = 6;
   localparam int LINES_W   = 3;
   localparam int LINE_IDX_W = 2;
   localparam int SLOT_IDX_W = 2;
   localparam int COUNT_W    = 3;

   // Configuration port widths.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Command bytes up to this value return the cursor to line one.
   localparam logic [VALUE_W-1:0] CMD_HOME_MAX = 8'h03;

   // Reset values of the configuration registers and the cursor.
   localparam logic [CURSOR_W-1:0]  LINE_ONE_RST   = 8'h80;
   localparam logic [CURSOR_W-1:0]  LINE_TWO_RST   = 8'hC0;
   localparam logic [CURSOR_W-1:0]  LINE_THREE_RST = 8'h94;
   localparam logic [CURSOR_W-1:0]  LINE_FOUR_RST  = 8'hD4;
   localparam logic [COLUMNS_W-1:0] COLUMNS_RST    = 6'd16;
   localparam logic [LINES_W-1:0]   LINES_RST      = 3'd2;

   // Input item kinds.
   typedef enum logic [MODE_W-1:0] {
      MODE_CHAR = 2'd0,
      MODE_CMD  = 2'd1,
      MODE_INIT = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   // Wait class after an enable pulse.
   typedef enum logic [SETTLE_W-1:0] {
      SETTLE_NONE  = 2'd0,
      SETTLE_DATA  = 2'd1,
      SETTLE_CLEAR = 2'd2
   } settle_type;

   // Configuration register indexes (byte address / 4).
   typedef enum logic [2:0] {
      REG_LINE_ONE   = 3'd0,
      REG_LINE_TWO   = 3'd1,
      REG_LINE_THREE = 3'd2,
      REG_LINE_FOUR  = 3'd3,
      REG_COLUMNS    = 3'd4,
      REG_LINES      = 3'd5
   } reg_idx_type;

   // One bus transfer as it leaves the block.
   typedef struct packed {
      logic [NIBBLE_W-1:0] nibble;
      logic                reg_select;
      settle_type          settle;
      logic [CURSOR_W-1:0] cursor;
   } xfer_type;

endpackage

>>> rtl/char_lcd_nibble_writer_core.sv
// ---------------------------------------------------------------------------
// Character LCD nibble writer core
// Turns characters, command bytes and init nibbles into 4-bit bus transfers
// and tracks the display cursor, wrapping to the next configured line.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_stall | req_mode, req_value
//   rsp     | out       | rsp_valid / rsp_stall | rsp_nibble, rsp_reg_select,
//           |           |                       | rsp_settle, rsp_cursor, rsp_last
//   csr     | in/out    | APB-style, pready = 1 | six registers at 4*index
//
// An item is held in the input register, then its transfers are built in
// one pass and leave one per cycle through the single result port while
// rsp_stall is low; an item has 1, 2 or 4 transfers.
// Its first transfer becomes valid once the item is loaded from the input
// register into the slot registers.
// The input register takes a new item while the previous item's transfers drain.
// Reset (synchronous) clears the cursor to 0x80 and the registers to their defaults.
// A stall on the result side holds the current transfer and backs up into req_stall.
// ---------------------------------------------------------------------------
module char_lcd_nibble_writer_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input item channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [clnw_pkg::MODE_W-1:0]         req_mode,
   input  logic [clnw_pkg::VALUE_W-1:0]        req_value,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [clnw_pkg::NIBBLE_W-1:0]       rsp_nibble,
   output logic                                rsp_reg_select,
   output logic [clnw_pkg::SETTLE_W-1:0]       rsp_settle,
   output logic [clnw_pkg::CURSOR_W-1:0]       rsp_cursor,
   output logic                                rsp_last,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [clnw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [clnw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [clnw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   logic [clnw_pkg::CURSOR_W-1:0]  line_addr_ff [clnw_pkg::MAX_LINES];
   logic [clnw_pkg::COLUMNS_W-1:0] columns_ff;
   logic [clnw_pkg::LINES_W-1:0]   lines_ff;
   logic [clnw_pkg::CURSOR_W-1:0]  cursor_ff;
   logic [clnw_pkg::CURSOR_W-1:0]  cursor_in;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   clnw_pkg::mode_type             in_mode_ff;
   logic [clnw_pkg::VALUE_W-1:0]   in_value_ff;

   clnw_pkg::xfer_type             slot_ff [clnw_pkg::MAX_RESULTS];
   clnw_pkg::xfer_type             slot_in [clnw_pkg::MAX_RESULTS];
   logic [clnw_pkg::COUNT_W-1:0]   left_ff;
   logic [clnw_pkg::COUNT_W-1:0]   left_in;
   logic [clnw_pkg::COUNT_W-1:0]   build_count;
   logic [clnw_pkg::SLOT_IDX_W-1:0] idx_ff;
   logic [clnw_pkg::SLOT_IDX_W-1:0] idx_in;

   logic                           req_take;
   logic                           rsp_take;
   logic                           seq_free;
   logic                           load;
   logic                           csr_write;
   clnw_pkg::reg_idx_type          csr_idx;
   clnw_pkg::xfer_type             rsp_xfer;

   // ------------------------------------------------------------------------
   // Command byte effects on the cursor and the settle class
   // ------------------------------------------------------------------------
   function automatic logic [clnw_pkg::CURSOR_W-1:0] cmd_cursor(
      input logic [clnw_pkg::VALUE_W-1:0]  cmd,
      input logic [clnw_pkg::CURSOR_W-1:0] home,
      input logic [clnw_pkg::CURSOR_W-1:0] cur
   );
      logic [clnw_pkg::CURSOR_W-1:0] res;
      if (cmd <= clnw_pkg::CMD_HOME_MAX) begin
         res = home;
      end else if (cmd[clnw_pkg::VALUE_W-1]) begin
         res = cmd;
      end else begin
         res = cur;
      end
      return res;
   endfunction

   function automatic clnw_pkg::settle_type cmd_settle(
      input logic [clnw_pkg::VALUE_W-1:0] cmd
   );
      clnw_pkg::settle_type res;
      if (cmd <= clnw_pkg::CMD_HOME_MAX) begin
         res = clnw_pkg::SETTLE_CLEAR;
      end else begin
         res = clnw_pkg::SETTLE_DATA;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   assign rsp_valid = (left_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign seq_free  = (left_ff == '0) ||
                      ((left_ff == clnw_pkg::COUNT_W'(1)) && rsp_take);
   assign load      = in_valid_ff && seq_free;
   assign req_stall = in_valid_ff && !seq_free;
   assign req_take  = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = clnw_pkg::reg_idx_type'(csr_paddr[clnw_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_addr_ff[0] <= clnw_pkg::LINE_ONE_RST;
         line_addr_ff[1] <= clnw_pkg::LINE_TWO_RST;
         line_addr_ff[2] <= clnw_pkg::LINE_THREE_RST;
         line_addr_ff[3] <= clnw_pkg::LINE_FOUR_RST;
         columns_ff      <= clnw_pkg::COLUMNS_RST;
         lines_ff        <= clnw_pkg::LINES_RST;
      end else if (csr_write) begin
         unique case (csr_idx)
            clnw_pkg::REG_LINE_ONE: begin
               line_addr_ff[0] <= csr_pwdata[clnw_pkg::CURSOR_W-1:0];
            end
            clnw_pkg::REG_LINE_TWO: begin
               line_addr_ff[1] <= csr_pwdata[clnw_pkg::CURSOR_W-1:0];
            end
            clnw_pkg::REG_LINE_THREE: begin
               line_addr_ff[2] <= csr_pwdata[clnw_pkg::CURSOR_W-1:0];
            end
            clnw_pkg::REG_LINE_FOUR: begin
               line_addr_ff[3] <= csr_pwdata[clnw_pkg::CURSOR_W-1:0];
            end
            clnw_pkg::REG_COLUMNS: begin
               columns_ff <= csr_pwdata[clnw_pkg::COLUMNS_W-1:0];
            end
            clnw_pkg::REG_LINES: begin
               lines_ff <= csr_pwdata[clnw_pkg::LINES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read data is the addressed register, zero extended.
   always_comb begin
      unique case (csr_idx)
         clnw_pkg::REG_LINE_ONE:   csr_prdata = clnw_pkg::CSR_DATA_W'(line_addr_ff[0]);
         clnw_pkg::REG_LINE_TWO:   csr_prdata = clnw_pkg::CSR_DATA_W'(line_addr_ff[1]);
         clnw_pkg::REG_LINE_THREE: csr_prdata = clnw_pkg::CSR_DATA_W'(line_addr_ff[2]);
         clnw_pkg::REG_LINE_FOUR:  csr_prdata = clnw_pkg::CSR_DATA_W'(line_addr_ff[3]);
         clnw_pkg::REG_COLUMNS:    csr_prdata = clnw_pkg::CSR_DATA_W'(columns_ff);
         clnw_pkg::REG_LINES:      csr_prdata = clnw_pkg::CSR_DATA_W'(lines_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Input register; items of the unused mode cause nothing and are dropped.
   // ------------------------------------------------------------------------
   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = (clnw_pkg::mode_type'(req_mode) != clnw_pkg::MODE_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff  <= clnw_pkg::mode_type'(req_mode);
         in_value_ff <= req_value;
      end
   end

   // ------------------------------------------------------------------------
   // Transfer builder: all transfers of the held item and the new cursor.
   // ------------------------------------------------------------------------
   always_comb begin
      logic [clnw_pkg::LINES_W-1:0]    n_lines;
      logic [clnw_pkg::CURSOR_W-1:0]   cur_inc;
      logic [clnw_pkg::CURSOR_W:0]     line_end;
      logic [clnw_pkg::MAX_LINES-1:0]  hit;
      logic                            wrap;
      logic [clnw_pkg::LINE_IDX_W-1:0] hit_idx;
      logic [clnw_pkg::LINE_IDX_W-1:0] next_idx;
      logic [clnw_pkg::CURSOR_W-1:0]   wrap_cmd;

      // Lines in use, clamped to one through MAX_LINES.
      if (lines_ff == '0) begin
         n_lines = clnw_pkg::LINES_W'(1);
      end else if (lines_ff > clnw_pkg::LINES_W'(clnw_pkg::MAX_LINES)) begin
         n_lines = clnw_pkg::LINES_W'(clnw_pkg::MAX_LINES);
      end else begin
         n_lines = lines_ff;
      end

      // Line end test against each line in use, 9-bit sums.
      cur_inc = cursor_ff + clnw_pkg::CURSOR_W'(1);
      for (int k = 0; k < clnw_pkg::MAX_LINES; k++) begin
         line_end = {1'b0, line_addr_ff[k]} + (clnw_pkg::CURSOR_W+1)'(columns_ff);
         hit[k]   = (line_end == {1'b0, cur_inc}) &&
                    (clnw_pkg::LINES_W'(k) < n_lines);
      end

      // The first matching line wins.
      wrap    = 1'b0;
      hit_idx = '0;
      for (int k = clnw_pkg::MAX_LINES - 1; k >= 0; k--) begin
         if (hit[k]) begin
            wrap    = 1'b1;
            hit_idx = clnw_pkg::LINE_IDX_W'(k);
         end
      end
      if ((clnw_pkg::LINES_W'(hit_idx) + clnw_pkg::LINES_W'(1)) < n_lines) begin
         next_idx = hit_idx + clnw_pkg::LINE_IDX_W'(1);
      end else begin
         next_idx = '0;
      end
      wrap_cmd = line_addr_ff[next_idx];

      // Defaults: keep cursor, first transfer is the high nibble.
      cursor_in   = cursor_ff;
      build_count = '0;
      for (int s = 0; s < clnw_pkg::MAX_RESULTS; s++) begin
         slot_in[s] = slot_ff[s];
      end
      slot_in[0].nibble     = in_value_ff[clnw_pkg::VALUE_W-1:clnw_pkg::NIBBLE_W];
      slot_in[0].reg_select = 1'b0;
      slot_in[0].settle     = clnw_pkg::SETTLE_NONE;
      slot_in[0].cursor     = cursor_ff;

      unique case (in_mode_ff)
         clnw_pkg::MODE_CHAR: begin
            slot_in[0].reg_select = 1'b1;
            slot_in[1].nibble     = in_value_ff[clnw_pkg::NIBBLE_W-1:0];
            slot_in[1].reg_select = 1'b1;
            slot_in[1].settle     = clnw_pkg::SETTLE_DATA;
            slot_in[1].cursor     = cur_inc;
            // Set-position command for the next line when the line is full.
            slot_in[2].nibble     = wrap_cmd[clnw_pkg::CURSOR_W-1:clnw_pkg::NIBBLE_W];
            slot_in[2].reg_select = 1'b0;
            slot_in[2].settle     = clnw_pkg::SETTLE_NONE;
            slot_in[2].cursor     = cur_inc;
            slot_in[3].nibble     = wrap_cmd[clnw_pkg::NIBBLE_W-1:0];
            slot_in[3].reg_select = 1'b0;
            slot_in[3].settle     = cmd_settle(wrap_cmd);
            slot_in[3].cursor     = cmd_cursor(wrap_cmd, line_addr_ff[0], cur_inc);
            if (wrap) begin
               cursor_in   = slot_in[3].cursor;
               build_count = clnw_pkg::COUNT_W'(4);
            end else begin
               cursor_in   = cur_inc;
               build_count = clnw_pkg::COUNT_W'(2);
            end
         end
         clnw_pkg::MODE_CMD: begin
            slot_in[1].nibble     = in_value_ff[clnw_pkg::NIBBLE_W-1:0];
            slot_in[1].reg_select = 1'b0;
            slot_in[1].settle     = cmd_settle(in_value_ff);
            slot_in[1].cursor     = cmd_cursor(in_value_ff, line_addr_ff[0], cursor_ff);
            cursor_in             = slot_in[1].cursor;
            build_count           = clnw_pkg::COUNT_W'(2);
         end
         clnw_pkg::MODE_INIT: begin
            build_count = clnw_pkg::COUNT_W'(1);
         end
         default: begin
            build_count = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Result sequencer: one transfer per cycle from the slot registers, while rsp_stall is low.
   // ------------------------------------------------------------------------
   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (load) begin
         left_in = build_count;
         idx_in  = '0;
      end else if (rsp_take) begin
         left_in = left_ff - clnw_pkg::COUNT_W'(1);
         idx_in  = idx_ff + clnw_pkg::SLOT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         idx_ff    <= '0;
         cursor_ff <= clnw_pkg::LINE_ONE_RST;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
         if (load) begin
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int s = 0; s < clnw_pkg::MAX_RESULTS; s++) begin
            slot_ff[s] <= slot_in[s];
         end
      end
   end

   // Result fields.
   assign rsp_xfer       = slot_ff[idx_ff];
   assign rsp_nibble     = rsp_xfer.nibble;
   assign rsp_reg_select = rsp_xfer.reg_select;
   assign rsp_settle     = rsp_xfer.settle;
   assign rsp_cursor     = rsp_xfer.cursor;
   assign rsp_last       = (left_ff == clnw_pkg::COUNT_W'(1));

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The sequencer never holds more transfers than one item can cause.
   assert property (@(posedge clock) disable iff (reset)
      left_ff <= clnw_pkg::COUNT_W'(clnw_pkg::MAX_RESULTS))
      else $error("sequencer count exceeds the transfer limit");

   // The cursor moves only when an item is loaded into the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(cursor_ff))
      else $error("cursor changed without an item being loaded");

   // A loaded item always leaves at least one transfer pending.
   assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded item produced no transfer");

   // The input side is only stalled by an item waiting in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid)
      else $error("input stalled with nothing waiting");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Character LCD nibble writer testbench
// Drives characters, commands and init nibbles into the writer. A local
// model of the cursor and the line-wrap logic predicts every bus transfer.
// The testbench compares each transfer field by field, with random idle
// cycles on both channels. It steps through several line and column
// settings through the configuration port and reads each one back.
// ---------------------------------------------------------------------------
module tb;

   // One expected bus transfer.
   typedef struct packed {
      logic [clnw_pkg::NIBBLE_W-1:0] nibble;
      logic                          reg_select;
      clnw_pkg::settle_type          settle;
      logic [clnw_pkg::CURSOR_W-1:0] cursor;
      logic                          last;
   } bus_xfer_type;

   // One stimulus row. When typed is set, the final transfer of the item is
   // given here by hand instead of coming from the model.
   typedef struct packed {
      clnw_pkg::mode_type            mode;
      logic [clnw_pkg::VALUE_W-1:0]  value;
      logic                          typed;
      logic [clnw_pkg::NIBBLE_W-1:0] nibble;
      logic                          reg_select;
      clnw_pkg::settle_type          settle;
      logic [clnw_pkg::CURSOR_W-1:0] cursor;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam int PHASES        = 6;
   localparam int ITEMS_PER_PHASE = 12;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [clnw_pkg::MODE_W-1:0]     req_mode = '0;
   logic [clnw_pkg::VALUE_W-1:0]    req_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [clnw_pkg::NIBBLE_W-1:0]   rsp_nibble;
   logic                            rsp_reg_select;
   logic [clnw_pkg::SETTLE_W-1:0]   rsp_settle;
   logic [clnw_pkg::CURSOR_W-1:0]   rsp_cursor;
   logic                            rsp_last;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [clnw_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [clnw_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [clnw_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Shadow copy of the configuration and the tracked cursor.
   logic [clnw_pkg::CURSOR_W-1:0]  line_start [clnw_pkg::MAX_LINES];
   logic [clnw_pkg::COLUMNS_W-1:0] col_count;
   logic [clnw_pkg::LINES_W-1:0]   line_count;
   logic [clnw_pkg::CURSOR_W-1:0]  cursor_track;

   bus_xfer_type pending_xfers [$];
   int           mismatch_count = 0;
   bit           idle_on = 1'b1;

   // Directed rows, walked in order right after reset with default settings.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{clnw_pkg::MODE_INIT, 8'h30, 1'b1, 4'h3, 1'b0, clnw_pkg::SETTLE_NONE,  8'h80},
      '{clnw_pkg::MODE_INIT, 8'h20, 1'b1, 4'h2, 1'b0, clnw_pkg::SETTLE_NONE,  8'h80},
      '{clnw_pkg::MODE_CMD,  8'h28, 1'b1, 4'h8, 1'b0, clnw_pkg::SETTLE_DATA,  8'h80},
      '{clnw_pkg::MODE_CMD,  8'h01, 1'b1, 4'h1, 1'b0, clnw_pkg::SETTLE_CLEAR, 8'h80},
      '{clnw_pkg::MODE_CMD,  8'h00, 1'b1, 4'h0, 1'b0, clnw_pkg::SETTLE_CLEAR, 8'h80},
      '{clnw_pkg::MODE_CMD,  8'h03, 1'b1, 4'h3, 1'b0, clnw_pkg::SETTLE_CLEAR, 8'h80},
      '{clnw_pkg::MODE_CMD,  8'h04, 1'b1, 4'h4, 1'b0, clnw_pkg::SETTLE_DATA,  8'h80},
      '{clnw_pkg::MODE_CMD,  8'h7F, 1'b1, 4'hF, 1'b0, clnw_pkg::SETTLE_DATA,  8'h80},
      '{clnw_pkg::MODE_CMD,  8'h80, 1'b1, 4'h0, 1'b0, clnw_pkg::SETTLE_DATA,  8'h80},
      '{clnw_pkg::MODE_CMD,  8'hFF, 1'b1, 4'hF, 1'b0, clnw_pkg::SETTLE_DATA,  8'hFF},
      '{clnw_pkg::MODE_CHAR, 8'h00, 1'b1, 4'h0, 1'b1, clnw_pkg::SETTLE_DATA,  8'h00},
      '{clnw_pkg::MODE_CHAR, 8'hFF, 1'b1, 4'hF, 1'b1, clnw_pkg::SETTLE_DATA,  8'h01},
      '{clnw_pkg::MODE_CMD,  8'h8E, 1'b1, 4'hE, 1'b0, clnw_pkg::SETTLE_DATA,  8'h8E},
      '{clnw_pkg::MODE_CHAR, 8'h41, 1'b0, 4'h0, 1'b0, clnw_pkg::SETTLE_NONE,  8'h00},
      '{clnw_pkg::MODE_CHAR, 8'h42, 1'b1, 4'h0, 1'b0, clnw_pkg::SETTLE_DATA,  8'hC0},
      '{clnw_pkg::MODE_CMD,  8'hCF, 1'b1, 4'hF, 1'b0, clnw_pkg::SETTLE_DATA,  8'hCF},
      '{clnw_pkg::MODE_CHAR, 8'h43, 1'b1, 4'h0, 1'b0, clnw_pkg::SETTLE_DATA,  8'h80},
      '{clnw_pkg::MODE_NONE, 8'h55, 1'b0, 4'h0, 1'b0, clnw_pkg::SETTLE_NONE,  8'h00},
      '{clnw_pkg::MODE_CHAR, 8'h7E, 1'b0, 4'h0, 1'b0, clnw_pkg::SETTLE_NONE,  8'h00},
      '{clnw_pkg::MODE_INIT, 8'hF0, 1'b1, 4'hF, 1'b0, clnw_pkg::SETTLE_NONE,  8'h81}
   };

   char_lcd_nibble_writer_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_nibble     (rsp_nibble),
      .rsp_reg_select (rsp_reg_select),
      .rsp_settle     (rsp_settle),
      .rsp_cursor     (rsp_cursor),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   // Queue one transfer, tagged with the cursor as it stands now.
   function automatic void push_xfer(logic [clnw_pkg::NIBBLE_W-1:0] nib, logic rs,
                                     clnw_pkg::settle_type st);
      bus_xfer_type x;
      x.nibble     = nib;
      x.reg_select = rs;
      x.settle     = st;
      x.cursor     = cursor_track;
      x.last       = 1'b0;
      pending_xfers.push_back(x);
   endfunction

   // A command byte: home commands and set-position commands move the cursor
   // between the two nibbles.
   function automatic void push_command(logic [clnw_pkg::VALUE_W-1:0] b);
      clnw_pkg::settle_type st;
      st = clnw_pkg::SETTLE_DATA;
      push_xfer(b[7:4], 1'b0, clnw_pkg::SETTLE_NONE);
      if (b <= clnw_pkg::CMD_HOME_MAX) begin
         st = clnw_pkg::SETTLE_CLEAR;
         cursor_track = line_start[0];
      end else if (b[7]) begin
         cursor_track = b;
      end
      push_xfer(b[3:0], 1'b0, st);
   endfunction

   // Expected transfers of one item, appended to the queue.
   function automatic void predict_transfers(clnw_pkg::mode_type m,
                                             logic [clnw_pkg::VALUE_W-1:0] v);
      int first;
      int lines_in_use;
      int nxt;
      bit wrapped;
      logic [8:0] line_end;
      first = pending_xfers.size();
      wrapped = 1'b0;
      unique case (m)
         clnw_pkg::MODE_CHAR: begin
            lines_in_use = int'(line_count);
            if (lines_in_use < 1) lines_in_use = 1;
            if (lines_in_use > clnw_pkg::MAX_LINES) lines_in_use = clnw_pkg::MAX_LINES;
            push_xfer(v[7:4], 1'b1, clnw_pkg::SETTLE_NONE);
            cursor_track = cursor_track + 8'd1;
            push_xfer(v[3:0], 1'b1, clnw_pkg::SETTLE_DATA);
            // The first line whose end the cursor hits sends the next line start.
            for (int k = 0; k < lines_in_use; k++) begin
               line_end = {1'b0, line_start[k]} + {3'b000, col_count};
               if (!wrapped && line_end == {1'b0, cursor_track}) begin
                  wrapped = 1'b1;
                  nxt = (k + 1 < lines_in_use) ? k + 1 : 0;
                  push_command(line_start[nxt]);
               end
            end
         end
         clnw_pkg::MODE_CMD:  push_command(v);
         clnw_pkg::MODE_INIT: push_xfer(v[7:4], 1'b0, clnw_pkg::SETTLE_NONE);
         default: ;
      endcase
      if (pending_xfers.size() > first)
         pending_xfers[pending_xfers.size()-1].last = 1'b1;
   endfunction

   // Present one item, hold it until accepted, then record its transfers.
   task automatic send_item(stim_row_type row);
      int gap;
      gap = (idle_on && $urandom_range(99) < 17) ? int'($urandom_range(1, 3)) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= row.mode;
      req_value <= row.value;
      do @(posedge clock); while (req_stall);
      predict_transfers(row.mode, row.value);
      if (row.typed)
         pending_xfers[pending_xfers.size()-1] =
            '{row.nibble, row.reg_select, row.settle, row.cursor, 1'b1};
   endtask

   // One APB-style access: setup cycle, then access cycle.
   task automatic csr_access(logic wr, clnw_pkg::reg_idx_type idx,
                             logic [clnw_pkg::CSR_DATA_W-1:0] data,
                             output logic [clnw_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write a register, mirror it in the shadow copy and read it back.
   task automatic csr_write(clnw_pkg::reg_idx_type idx, logic [clnw_pkg::CSR_DATA_W-1:0] data);
      logic [clnw_pkg::CSR_DATA_W-1:0] rdata;
      logic [clnw_pkg::CSR_DATA_W-1:0] want;
      csr_access(1'b1, idx, data, rdata);
      unique case (idx)
         clnw_pkg::REG_COLUMNS: begin
            col_count = data[clnw_pkg::COLUMNS_W-1:0];
            want = clnw_pkg::CSR_DATA_W'(col_count);
         end
         clnw_pkg::REG_LINES: begin
            line_count = data[clnw_pkg::LINES_W-1:0];
            want = clnw_pkg::CSR_DATA_W'(line_count);
         end
         default: begin
            line_start[idx] = data[clnw_pkg::CURSOR_W-1:0];
            want = clnw_pkg::CSR_DATA_W'(line_start[idx]);
         end
      endcase
      csr_access(1'b0, idx, '0, rdata);
      if (rdata !== want) begin
         $display("%0t: register %0d readback, expected %0h, actual %0h",
                  $time, idx, want, rdata);
         mismatch_count++;
      end
   endtask

   // Let every expected transfer drain, then allow for an item without results.
   task automatic wait_idle();
      while (pending_xfers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Line settings for each phase, fixed extremes for most phases and random ones for phase 4.
   task automatic configure(int phase);
      logic [7:0] a [clnw_pkg::MAX_LINES];
      logic [5:0] cols;
      logic [2:0] lines;
      unique case (phase)
         0: begin a = '{8'h80, 8'hC0, 8'h94, 8'hD4}; cols = 6'd1;  lines = 3'd4; end
         1: begin a = '{8'h80, 8'hC0, 8'h94, 8'hD4}; cols = 6'd40; lines = 3'd1; end
         2: begin a = '{8'h90, 8'hA0, 8'hB0, 8'hC0}; cols = 6'd0;  lines = 3'd0; end
         3: begin a = '{8'hFF, 8'hF0, 8'h00, 8'h7F}; cols = 6'd63; lines = 3'd7; end
         5: begin a = '{8'h00, 8'h80, 8'hFD, 8'h40}; cols = 6'd3;  lines = 3'd3; end
         default: begin
            foreach (a[i]) a[i] = 8'($urandom_range(0, 255));
            cols  = 6'($urandom_range(0, 63));
            lines = 3'($urandom_range(0, 7));
         end
      endcase
      csr_write(clnw_pkg::REG_LINE_ONE,   {24'h0, a[0]});
      csr_write(clnw_pkg::REG_LINE_TWO,   {24'h0, a[1]});
      csr_write(clnw_pkg::REG_LINE_THREE, {24'h0, a[2]});
      csr_write(clnw_pkg::REG_LINE_FOUR,  {24'h0, a[3]});
      csr_write(clnw_pkg::REG_COLUMNS,    {26'h0, cols});
      csr_write(clnw_pkg::REG_LINES,      {29'h0, lines});
   endtask

   // Random items: mostly a set-position near a line end followed by a run of
   // characters, so the wrap logic gets exercised, plus some noise.
   task automatic run_random(int count);
      int sent;
      int run_len;
      int back;
      stim_row_type row;
      sent = 0;
      row = '0;
      while (sent < count) begin
         if ($urandom_range(99) < 70) begin
            row.mode = clnw_pkg::MODE_CMD;
            back = int'($urandom_range(0, 3));
            if ($urandom_range(9) == 0)
               row.value = clnw_pkg::VALUE_W'($urandom_range(0, 3));
            else
               row.value = clnw_pkg::VALUE_W'(
                  line_start[$urandom_range(0, clnw_pkg::MAX_LINES-1)] + col_count - back);
            send_item(row);
            sent++;
            run_len = int'($urandom_range(1, 6));
            for (int i = 0; i < run_len; i++) begin
               row.mode  = clnw_pkg::MODE_CHAR;
               row.value = clnw_pkg::VALUE_W'($urandom_range(0, 255));
               send_item(row);
               sent++;
            end
         end else begin
            row.mode  = clnw_pkg::mode_type'($urandom_range(0, 3));
            row.value = clnw_pkg::VALUE_W'($urandom_range(0, 255));
            send_item(row);
            if (row.mode != clnw_pkg::MODE_NONE) sent++;
         end
      end
   endtask

   // Result side: random stalls, driven at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 17);
   end

   // Compare each accepted transfer with the oldest expectation.
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      bus_xfer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_xfers.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual %0h/%0b/%0d/%0h/%0b",
                     $time, rsp_nibble, rsp_reg_select, rsp_settle, rsp_cursor, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_xfers.pop_front();
            check_field("nibble", {4'h0, want.nibble}, {4'h0, rsp_nibble});
            check_field("reg_select", {7'h0, want.reg_select}, {7'h0, rsp_reg_select});
            check_field("settle", {6'h0, want.settle}, {6'h0, rsp_settle});
            check_field("cursor", want.cursor, rsp_cursor);
            check_field("last", {7'h0, want.last}, {7'h0, rsp_last});
         end
      end
   end

   // Main sequence: reset, directed rows, then the configured random phases.
   initial begin
      line_start   = '{clnw_pkg::LINE_ONE_RST, clnw_pkg::LINE_TWO_RST,
                       clnw_pkg::LINE_THREE_RST, clnw_pkg::LINE_FOUR_RST};
      col_count    = clnw_pkg::COLUMNS_RST;
      line_count   = clnw_pkg::LINES_RST;
      cursor_track = clnw_pkg::LINE_ONE_RST;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         wait_idle();
         configure(phase);
         // One phase runs with no idling on either side.
         idle_on = (phase != 2);
         run_random(ITEMS_PER_PHASE);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_idle();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
